### rtl/fastq_block_validator_defines.svh
// assertion helpers shared by the validator rtl
// each macro samples on i_clk and is switched off while i_rst_n is low
`ifndef FASTQ_BLOCK_VALIDATOR_DEFINES_SVH
`define FASTQ_BLOCK_VALIDATOR_DEFINES_SVH

// property checked at every clock edge outside reset
`define FQV_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// condition in one cycle implies a consequence in the next
`define FQV_ASSERT_NEXT(label, pre, post, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

### rtl/fqv_pkg.sv
// ----------------------------------------------------------------------------
// fqv_pkg
// types, constants and helpers of the fastq block validator
// ----------------------------------------------------------------------------
package fqv_pkg;

    // largest buffer the validator accepts, in bytes
    localparam longint unsigned BLOCK_BYTES_MAX = 64'd16777216;

    localparam int POS_W    = 24;
    localparam int OFFSET_W = POS_W + 1;

    // byte offset saturates here; positions at or past the limit fail the buffer
    localparam logic [OFFSET_W-1:0] OFFSET_SPAN  = {1'b1, {POS_W{1'b0}}};
    localparam logic [OFFSET_W-1:0] OFFSET_LIMIT =
        (BLOCK_BYTES_MAX < 64'(OFFSET_SPAN)) ? OFFSET_W'(BLOCK_BYTES_MAX) : OFFSET_SPAN;
    localparam logic [POS_W-1:0]    LEN_MAX      = {POS_W{1'b1}};

    // line end records needed before a buffer can pass
    localparam logic [2:0] REC_COUNT_FULL = 3'd4;

    // characters
    localparam logic [7:0] CHAR_NL = 8'h0A;
    localparam logic [7:0] CHAR_AT = 8'h40;

    // line phase within a record
    localparam logic [1:0] PHASE_ID   = 2'd0;
    localparam logic [1:0] PHASE_BASE = 2'd1;
    localparam logic [1:0] PHASE_PLUS = 2'd2;
    localparam logic [1:0] PHASE_QUAL = 2'd3;

    // result kinds
    localparam logic KIND_POS     = 1'b0;
    localparam logic KIND_VERDICT = 1'b1;

    // result buffer geometry
    localparam int BUF_DEPTH = 4;
    localparam int BUF_PTR_W = 2;
    localparam int BUF_LVL_W = 3;
    localparam logic [BUF_LVL_W-1:0] BUF_ROOM_MAX = BUF_LVL_W'(BUF_DEPTH - 2);
    localparam logic [BUF_LVL_W-1:0] BUF_FULL     = BUF_LVL_W'(BUF_DEPTH);

    typedef struct packed {
        logic             record_kind;
        logic [POS_W-1:0] position;
        logic [POS_W-1:0] max_base_length;
        logic             last;
    } t_result;

    // up to two results produced by one byte
    typedef struct packed {
        logic [1:0] count;
        t_result    res0;
        t_result    res1;
    } t_push;

    // nucleotide letters allowed at the start of a base line
    function automatic logic is_base_char(input logic [7:0] c);
        logic hit;
        hit = 1'b0;
        case (c)
            8'h41, 8'h43, 8'h47, 8'h54, 8'h4E,
            8'h61, 8'h63, 8'h67, 8'h74, 8'h6E: hit = 1'b1;
            default:                           hit = 1'b0;
        endcase
        return hit;
    endfunction

endpackage

### rtl/fqv_if.sv
// ----------------------------------------------------------------------------
// fqv_if
// valid/ready stream interfaces for input bytes and results
// ----------------------------------------------------------------------------
interface fqv_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;
    logic       end_of_file;

    modport source (output valid, output data_byte, output last_byte,
                    output end_of_file, input ready);
    modport sink   (input valid, input data_byte, input last_byte,
                    input end_of_file, output ready);
endinterface

interface fqv_out_if;
    logic                     valid;
    logic                     ready;
    logic                     record_kind;
    logic [fqv_pkg::POS_W-1:0] position;
    logic [fqv_pkg::POS_W-1:0] max_base_length;
    logic                     last;

    modport source (output valid, output record_kind, output position,
                    output max_base_length, output last, input ready);
    modport sink   (input valid, input record_kind, input position,
                    input max_base_length, input last, output ready);
endinterface

### rtl/fqv_check.sv
// ----------------------------------------------------------------------------
// fqv_check
// per-byte record checker: line state, length tracking and result generation
// ----------------------------------------------------------------------------
module fqv_check (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_fire,
    input  logic [7:0]     i_data_byte,
    input  logic           i_last_byte,
    input  logic           i_end_of_file,
    output fqv_pkg::t_push o_push
);

    logic [fqv_pkg::OFFSET_W-1:0] r_byte_offset, n_byte_offset;
    logic [1:0]                   r_phase, n_phase;
    logic [2:0]                   r_count, n_count;
    logic [fqv_pkg::POS_W-1:0]    r_len, n_len;
    logic                         r_fco, n_fco;
    logic [fqv_pkg::POS_W-1:0]    r_base, n_base;
    logic [fqv_pkg::POS_W-1:0]    r_longest, n_longest;
    logic                         r_failed, n_failed;

    // next state and results of the byte at the input register
    always_comb begin
        logic                      v_is_nl;
        logic                      v_fco;
        logic                      v_ok;
        logic [fqv_pkg::POS_W-1:0] v_here;
        logic [fqv_pkg::POS_W-1:0] v_verdict;

        n_byte_offset = r_byte_offset;
        n_phase       = r_phase;
        n_count       = r_count;
        n_len         = r_len;
        n_fco         = r_fco;
        n_base        = r_base;
        n_longest     = r_longest;
        n_failed      = r_failed || (r_byte_offset >= fqv_pkg::OFFSET_LIMIT);
        v_is_nl       = (i_data_byte == fqv_pkg::CHAR_NL);
        v_fco         = 1'b0;
        v_ok          = 1'b1;
        v_here        = r_byte_offset[fqv_pkg::POS_W-1:0];
        v_verdict     = '0;
        o_push        = '0;

        // line tracking while the buffer is still good
        if (!n_failed) begin
            if (v_is_nl) begin
                o_push.count            = 2'd1;
                o_push.res0.record_kind = fqv_pkg::KIND_POS;
                o_push.res0.position    = v_here;
                if (n_count < fqv_pkg::REC_COUNT_FULL) begin
                    n_count = n_count + 3'd1;
                end
                v_fco = (r_len == '0) ? 1'b0 : r_fco;
                case (r_phase)
                    fqv_pkg::PHASE_ID: begin
                        v_ok = v_fco;
                    end
                    fqv_pkg::PHASE_BASE: begin
                        n_base = r_len;
                        if (r_len > r_longest) begin
                            n_longest = r_len;
                        end
                        v_ok = v_fco;
                    end
                    fqv_pkg::PHASE_QUAL: begin
                        v_ok = (r_len == r_base);
                    end
                    default: begin
                        v_ok = 1'b1;
                    end
                endcase
                n_failed = !v_ok;
                n_phase  = r_phase + 2'd1;
                n_len    = '0;
                n_fco    = 1'b0;
            end else begin
                // first character of a line
                if (r_len == '0) begin
                    case (r_phase)
                        fqv_pkg::PHASE_ID:   n_fco = (i_data_byte == fqv_pkg::CHAR_AT);
                        fqv_pkg::PHASE_BASE: n_fco = fqv_pkg::is_base_char(i_data_byte);
                        default:             n_fco = 1'b1;
                    endcase
                end
                if (r_len < fqv_pkg::LEN_MAX) begin
                    n_len = r_len + 1'b1;
                end
            end
        end

        // saturating byte offset
        if (r_byte_offset < fqv_pkg::OFFSET_SPAN) begin
            n_byte_offset = r_byte_offset + 1'b1;
        end

        // end of buffer: optional unterminated line record, then verdict
        if (i_last_byte) begin
            if (i_end_of_file && !n_failed && !v_is_nl) begin
                o_push.count            = 2'd1;
                o_push.res0.record_kind = fqv_pkg::KIND_POS;
                o_push.res0.position    = v_here;
                if (n_count < fqv_pkg::REC_COUNT_FULL) begin
                    n_count = n_count + 3'd1;
                end
            end
            v_verdict = (n_failed || (n_count < fqv_pkg::REC_COUNT_FULL)) ? '0 : n_longest;
            if (o_push.count == 2'd0) begin
                o_push.res0.record_kind     = fqv_pkg::KIND_VERDICT;
                o_push.res0.max_base_length = v_verdict;
                o_push.res0.last            = 1'b1;
            end else begin
                o_push.res1.record_kind     = fqv_pkg::KIND_VERDICT;
                o_push.res1.max_base_length = v_verdict;
                o_push.res1.last            = 1'b1;
            end
            o_push.count  = o_push.count + 2'd1;
            n_byte_offset = '0;
            n_phase       = fqv_pkg::PHASE_ID;
            n_count       = '0;
            n_len         = '0;
            n_fco         = 1'b0;
            n_base        = '0;
            n_longest     = '0;
            n_failed      = 1'b0;
        end

        // nothing leaves without a beat in the input register
        if (!i_fire) begin
            o_push.count = 2'd0;
        end
    end

    // checker state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_offset <= '0;
            r_phase       <= fqv_pkg::PHASE_ID;
            r_count       <= '0;
            r_len         <= '0;
            r_fco         <= 1'b0;
            r_base        <= '0;
            r_longest     <= '0;
            r_failed      <= 1'b0;
        end else if (i_fire) begin
            r_byte_offset <= n_byte_offset;
            r_phase       <= n_phase;
            r_count       <= n_count;
            r_len         <= n_len;
            r_fco         <= n_fco;
            r_base        <= n_base;
            r_longest     <= n_longest;
            r_failed      <= n_failed;
        end
    end

endmodule

### rtl/fqv_obuf.sv
// ----------------------------------------------------------------------------
// fqv_obuf
// result buffer: takes up to two results per cycle, sends one per ready cycle
// ----------------------------------------------------------------------------
module fqv_obuf (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  fqv_pkg::t_push                    i_push,
    output logic                              o_room,
    output logic [fqv_pkg::BUF_LVL_W-1:0]     o_level,
    fqv_out_if.source                         o_out
);

    fqv_pkg::t_result                 r_mem [fqv_pkg::BUF_DEPTH];
    logic [fqv_pkg::BUF_PTR_W-1:0]    r_wr_ptr, n_wr_ptr;
    logic [fqv_pkg::BUF_PTR_W-1:0]    r_rd_ptr, n_rd_ptr;
    logic [fqv_pkg::BUF_LVL_W-1:0]    r_level, n_level;
    logic                             w_pop;
    logic [fqv_pkg::BUF_PTR_W-1:0]    w_wr_ptr1;

    assign w_pop     = o_out.valid && o_out.ready;
    assign w_wr_ptr1 = r_wr_ptr + 1'b1;

    // pointer and fill level bookkeeping
    always_comb begin
        n_wr_ptr = r_wr_ptr + fqv_pkg::BUF_PTR_W'(i_push.count);
        n_rd_ptr = w_pop ? r_rd_ptr + 1'b1 : r_rd_ptr;
        n_level  = r_level + fqv_pkg::BUF_LVL_W'(i_push.count)
                 - fqv_pkg::BUF_LVL_W'(w_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_level  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_level  <= n_level;
        end
    end

    // result storage
    always_ff @(posedge i_clk) begin
        if (i_push.count != 2'd0) begin
            r_mem[r_wr_ptr] <= i_push.res0;
        end
        if (i_push.count == 2'd2) begin
            r_mem[w_wr_ptr1] <= i_push.res1;
        end
    end

    // output beat straight from storage
    assign o_out.valid           = (r_level != '0);
    assign o_out.record_kind     = r_mem[r_rd_ptr].record_kind;
    assign o_out.position        = r_mem[r_rd_ptr].position;
    assign o_out.max_base_length = r_mem[r_rd_ptr].max_base_length;
    assign o_out.last            = r_mem[r_rd_ptr].last;

    assign o_room  = (r_level <= fqv_pkg::BUF_ROOM_MAX);
    assign o_level = r_level;

endmodule

### rtl/fastq_block_validator.sv
// throughput: one byte per cycle while the result buffer has room, which needs
//   the output to be taken; a byte that gives two results (line end or
//   unterminated line plus verdict) sends them as two beats through the single-beat result buffer port
// reset: synchronous active-low i_rst_n clears line state, input register and buffer
// ----------------------------------------------------------------------------
// fastq_block_validator
// streaming fastq record format check over one buffer, one byte per beat
// ----------------------------------------------------------------------------
`include "fastq_block_validator_defines.svh"

module fastq_block_validator (
    input  logic      i_clk,
    input  logic      i_rst_n,
    fqv_in_if.sink    i_in,
    fqv_out_if.source o_out
);

    logic                              r_in_valid;
    logic [7:0]                        r_in_byte;
    logic                              r_in_last;
    logic                              r_in_eof;
    logic                              w_fire;
    logic                              w_room;
    logic [fqv_pkg::BUF_LVL_W-1:0]     w_level;
    fqv_pkg::t_push                    w_push;

    // input register: refills in the same cycle that its beat moves on
    assign w_fire     = r_in_valid && w_room;
    assign i_in.ready = !r_in_valid || w_fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.valid && i_in.ready) begin
            r_in_valid <= 1'b1;
        end else if (w_fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in_byte <= i_in.data_byte;
            r_in_last <= i_in.last_byte;
            r_in_eof  <= i_in.end_of_file;
        end
    end

    // record checker
    fqv_check u_check (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_fire        (w_fire),
        .i_data_byte   (r_in_byte),
        .i_last_byte   (r_in_last),
        .i_end_of_file (r_in_eof),
        .o_push        (w_push)
    );

    // result buffer
    fqv_obuf u_obuf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .o_room  (w_room),
        .o_level (w_level),
        .o_out   (o_out)
    );

    // checks
    `FQV_ASSERT(a_verdict_ends_buffer, w_fire && r_in_last |-> ((w_push.count == 2'd1) && (w_push.res0.record_kind == fqv_pkg::KIND_VERDICT)) || ((w_push.count == 2'd2) && w_push.res1.last && !w_push.res0.last), "last byte must end with exactly one verdict")
    `FQV_ASSERT(a_one_result_mid_buffer, w_fire && !r_in_last |-> (w_push.count <= 2'd1) && !w_push.res0.last, "byte inside a buffer gave more than a line end record")
    `FQV_ASSERT(a_buffer_bound, w_level <= fqv_pkg::BUF_FULL, "result buffer overfilled")
    `FQV_ASSERT_NEXT(a_stalled_byte_held, r_in_valid && !w_fire, r_in_valid && $stable(r_in_byte) && $stable(r_in_last), "stalled input register changed")

endmodule
